[rtl/tcw_pkg.sv]
package tcw_pkg;

	typedef enum logic [1:0] {
		CMD_PRINT = 2'd0,
		CMD_PUT   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_READ   = 6'b000100,
		S_SCROLL = 6'b001000,
		S_BLANK  = 6'b010000,
		S_CLEAR  = 6'b100000
	} state_t;

	localparam logic [7:0] LINE_FEED  = 8'd10;
	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'd10;

endpackage

[rtl/text_console_writer.sv]
// Channel   | Direction | Signals                                            | Handshake
// ----------+-----------+----------------------------------------------------+----------------------
// command   | in        | command, char_code, cell_attribute, cell_address   | start & !busy
// result    | out       | read_cell, cursor_column, cursor_line, scrolled    | done, one cycle
// config    | in        | cfg_data (default attribute)                       | cfg_valid & cfg_ready
//
// Print and put report done straight from idle; an in-range read cell passes S_READ for the
// registered memory read, and one beyond the store reports done at once. Clear walks all
// cells in S_CLEAR. A line feed or a wrap on the last line scrolls: S_SCROLL copies each line
// up and S_BLANK blanks the last line, one cell per cycle through the single write port.
// After reset the store is filled with blanks while busy is high.
// The result is shown for one cycle on done and the receiver cannot stall it; the default
// attribute is taken only while the block is idle and no command is offered.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int WIDTH  = 80,
	parameter int HEIGHT = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [7:0]  char_code,
	input  logic [7:0]  cell_attribute,
	input  logic [10:0] cell_address,
	output logic        done,
	output logic [15:0] read_cell,
	output logic [6:0]  cursor_column,
	output logic [4:0]  cursor_line,
	output logic        scrolled,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int CELLS = WIDTH * HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(WIDTH);
	localparam int LW    = $clog2(HEIGHT);

	logic [15:0]   mem [CELLS];
	logic [15:0]   rd_data_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;

	state_t        state_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] col_q;
	logic [LW-1:0] line_q;
	logic [AW-1:0] base_q;
	logic [7:0]    attr_q;
	logic          pend_s1;
	logic [AW-1:0] addr_s1;
	logic          done_q;
	logic          scrolled_q;
	logic [15:0]   read_cell_q;

	logic          accept;
	cmd_t          cmd;
	logic          is_lf;
	logic          wrap;
	logic          last_line;
	logic          in_range;
	logic [15:0]   blank;
	logic [15:0]   put_cell;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cmd       = cmd_t'(command);
	assign is_lf     = (cmd == CMD_PRINT) && (char_code == LINE_FEED);
	assign wrap      = (col_q == CW'(WIDTH - 1));
	assign last_line = (line_q == LW'(HEIGHT - 1));
	assign in_range  = (32'(cell_address) < 32'(CELLS));
	assign blank     = {attr_q, BLANK_CHAR};
	assign put_cell  = (cmd == CMD_PRINT) ? {attr_q, char_code} : {cell_attribute, char_code};
	assign cfg_ready = !busy && !start;

	assign done          = done_q;
	assign read_cell     = read_cell_q;
	assign scrolled      = scrolled_q;
	assign cursor_column = 7'(col_q);
	assign cursor_line   = 5'(line_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = blank;
		priority if (pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s1;
			mem_wdata = rd_data_q;
		end else if (state_q == S_INIT) begin
			mem_we    = 1'b1;
			mem_wdata = {RESET_ATTR, BLANK_CHAR};
		end else if (state_q == S_CLEAR || state_q == S_BLANK) begin
			mem_we    = 1'b1;
		end else if (accept && (cmd == CMD_PUT || (cmd == CMD_PRINT && !is_lf))) begin
			mem_we    = 1'b1;
			mem_waddr = base_q + AW'(col_q);
			mem_wdata = put_cell;
		end else begin
			mem_we    = 1'b0;
		end
		mem_raddr = (state_q == S_SCROLL) ? idx_q + AW'(WIDTH) : AW'(cell_address);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		addr_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			idx_q       <= '0;
			col_q       <= '0;
			line_q      <= '0;
			base_q      <= '0;
			pend_s1     <= 1'b0;
			done_q      <= 1'b0;
			scrolled_q  <= 1'b0;
			read_cell_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					if (idx_q == AW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						read_cell_q <= '0;
						scrolled_q  <= 1'b0;
						idx_q       <= '0;
						unique case (cmd)
							CMD_PRINT, CMD_PUT: begin
								if (is_lf || wrap) begin
									col_q <= '0;
									if (last_line) begin
										state_q <= S_SCROLL;
									end else begin
										line_q <= line_q + 1'b1;
										base_q <= base_q + AW'(WIDTH);
										done_q <= 1'b1;
									end
								end else begin
									col_q  <= col_q + 1'b1;
									done_q <= 1'b1;
								end
							end
							CMD_CLEAR: begin
								state_q <= S_CLEAR;
							end
							CMD_READ: begin
								if (in_range) begin
									state_q <= S_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					read_cell_q <= rd_data_q;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SCROLL: begin
					if (idx_q == AW'(CELLS - WIDTH)) begin
						pend_s1 <= 1'b0;
						state_q <= S_BLANK;
					end else begin
						pend_s1 <= 1'b1;
						idx_q   <= idx_q + 1'b1;
					end
				end
				S_BLANK, S_CLEAR: begin
					if (idx_q == AW'(CELLS - 1)) begin
						done_q     <= 1'b1;
						scrolled_q <= (state_q == S_BLANK);
						state_q    <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe outside idle");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && scrolled_q) |-> (last_line && col_q == '0))
		else $error("scroll left the cursor off the start of the last line");

	a_pend_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> state_q == S_SCROLL)
		else $error("pending copy write outside scroll");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < 32'(WIDTH)) && (32'(line_q) < 32'(HEIGHT)))
		else $error("cursor out of range");

	a_base_line: assert property (@(posedge clk) disable iff (!arst_n)
		32'(base_q) == 32'(line_q) * 32'(WIDTH))
		else $error("line base does not match cursor line");

endmodule

[sim/text_console_checker.sv]
`timescale 1ns / 100ps

module text_console_checker
	import tcw_pkg::*;
#(
	parameter int WIDTH  = 80,
	parameter int HEIGHT = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  command,
	input  logic [7:0]  char_code,
	input  logic [7:0]  cell_attribute,
	input  logic [10:0] cell_address,
	input  logic        done,
	input  logic [15:0] read_cell,
	input  logic [6:0]  cursor_column,
	input  logic [4:0]  cursor_line,
	input  logic        scrolled,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          pending,
	output int          checked_count,
	output int          scroll_count
);

	localparam int CELLS = WIDTH * HEIGHT;

	typedef struct packed {
		logic [15:0] cell_data;
		logic [6:0]  column;
		logic [4:0]  line;
		logic        scrolled;
	} console_result_t;

	logic [15:0]     screen_image [CELLS];
	int              cur_col;
	int              cur_line;
	logic [7:0]      blank_attr;
	console_result_t expected_q [$];
	int              fail_total;
	int              checked_total;
	int              scroll_total;

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++) begin
			screen_image[i] = {blank_attr, BLANK_CHAR};
		end
	endfunction

	function automatic logic feed_line();
		cur_col = 0;
		cur_line++;
		if (cur_line >= HEIGHT) begin
			for (int i = 0; i < CELLS - WIDTH; i++) begin
				screen_image[i] = screen_image[i + WIDTH];
			end
			for (int i = CELLS - WIDTH; i < CELLS; i++) begin
				screen_image[i] = {blank_attr, BLANK_CHAR};
			end
			cur_line = HEIGHT - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic store_char(logic [15:0] cell_data);
		screen_image[cur_col + cur_line * WIDTH] = cell_data;
		cur_col++;
		if (cur_col >= WIDTH) begin
			return feed_line();
		end
		return 1'b0;
	endfunction

	function automatic console_result_t predict_console(cmd_t cmd, logic [7:0] ch,
			logic [7:0] attr, logic [10:0] addr);
		console_result_t res;
		res = '0;
		case (cmd)
			CMD_PRINT: begin
				if (ch == LINE_FEED) begin
					res.scrolled = feed_line();
				end else begin
					res.scrolled = store_char({blank_attr, ch});
				end
			end
			CMD_PUT: begin
				res.scrolled = store_char({attr, ch});
			end
			CMD_CLEAR: begin
				blank_screen();
			end
			default: begin
				if (int'(addr) < CELLS) begin
					res.cell_data = screen_image[addr];
				end
			end
		endcase
		res.column = cur_col[6:0];
		res.line   = cur_line[4:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_result_t want;
		console_result_t got;
		if (!arst_n) begin
			blank_attr = RESET_ATTR;
			cur_col = 0;
			cur_line = 0;
			blank_screen();
			expected_q.delete();
			fail_total = 0;
			checked_total = 0;
			scroll_total = 0;
			fail_count <= 0;
			pending <= 0;
			checked_count <= 0;
			scroll_count <= 0;
		end else begin
			if (done) begin
				got = '{read_cell, cursor_column, cursor_line, scrolled};
				if (expected_q.size() == 0) begin
					if (fail_total < 10) begin
						$display("%0t: result with no command outstanding: cell %h col %0d line %0d scrolled %b",
							$realtime, got.cell_data, got.column, got.line, got.scrolled);
					end
					fail_total++;
				end else begin
					want = expected_q.pop_front();
					checked_total++;
					if (want.scrolled) begin
						scroll_total++;
					end
					if (got !== want) begin
						if (fail_total < 10) begin
							$display("%0t: mismatch: expected cell %h col %0d line %0d scrolled %b, got cell %h col %0d line %0d scrolled %b",
								$realtime, want.cell_data, want.column, want.line, want.scrolled,
								got.cell_data, got.column, got.line, got.scrolled);
						end
						fail_total++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				blank_attr = cfg_data;
			end
			if (start && !busy) begin
				expected_q.push_back(predict_console(cmd_t'(command), char_code,
					cell_attribute, cell_address));
			end
			fail_count <= fail_total;
			pending <= expected_q.size();
			checked_count <= checked_total;
			scroll_count <= scroll_total;
		end
	end

endmodule

[sim/text_console_writer_tb.sv]
`timescale 1ns / 100ps

module text_console_writer_tb;
	import tcw_pkg::*;

	localparam int WIDTH       = 80;
	localparam int HEIGHT      = 25;
	localparam int CELLS       = WIDTH * HEIGHT;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int LIMIT       = 20_000_000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [7:0]  char_code;
	logic [7:0]  cell_attribute;
	logic [10:0] cell_address;
	logic        done;
	logic [15:0] read_cell;
	logic [6:0]  cursor_column;
	logic [4:0]  cursor_line;
	logic        scrolled;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	int fail_count;
	int pending;
	int checked_count;
	int scroll_count;
	int cycle_count;
	int sent_count;
	int cmd_count [4];
	int attr_writes;
	bit quiet;

	text_console_writer #(
		.WIDTH (WIDTH),
		.HEIGHT(HEIGHT)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.char_code     (char_code),
		.cell_attribute(cell_attribute),
		.cell_address  (cell_address),
		.done          (done),
		.read_cell     (read_cell),
		.cursor_column (cursor_column),
		.cursor_line   (cursor_line),
		.scrolled      (scrolled),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	text_console_checker #(
		.WIDTH (WIDTH),
		.HEIGHT(HEIGHT)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.char_code     (char_code),
		.cell_attribute(cell_attribute),
		.cell_address  (cell_address),
		.done          (done),
		.read_cell     (read_cell),
		.cursor_column (cursor_column),
		.cursor_line   (cursor_line),
		.scrolled      (scrolled),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count),
		.scroll_count  (scroll_count)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic issue_command(cmd_t cmd, logic [7:0] ch, logic [7:0] attr,
			logic [10:0] addr);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		char_code <= ch;
		cell_attribute <= attr;
		cell_address <= addr;
		do @(posedge clk); while (busy);
		sent_count++;
		cmd_count[int'(cmd)]++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_attribute(logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		attr_writes++;
	endtask

	task automatic random_command(int lf_pct);
		int          pick;
		logic [7:0]  ch;
		logic [7:0]  attr;
		logic [10:0] addr;
		pick = $urandom_range(0, 99);
		ch = $urandom_range(0, 255);
		attr = $urandom_range(0, 255);
		if ($urandom_range(0, 99) < 85) begin
			addr = $urandom_range(0, CELLS - 1);
		end else begin
			addr = $urandom_range(CELLS, 2047);
		end
		if (pick < 50) begin
			if ($urandom_range(0, 99) < lf_pct) begin
				ch = LINE_FEED;
			end
			issue_command(CMD_PRINT, ch, attr, addr);
		end else if (pick < 77) begin
			issue_command(CMD_PUT, ch, attr, addr);
		end else if (pick < 97) begin
			issue_command(CMD_READ, ch, attr, addr);
		end else begin
			issue_command(CMD_CLEAR, ch, attr, addr);
		end
	endtask

	initial begin
		logic [7:0] attr_plan [PHASES];
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_PRINT;
		char_code = '0;
		cell_attribute = '0;
		cell_address = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		sent_count = 0;
		attr_writes = 0;
		quiet = 1'b0;
		foreach (cmd_count[i]) begin
			cmd_count[i] = 0;
		end
		attr_plan = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h0F, 8'h00, 8'hF0, 8'h00};
		for (int p = 1; p < PHASES; p += 2) begin
			attr_plan[p] = $urandom_range(0, 255);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		issue_command(CMD_READ, 8'h00, 8'h00, 11'd0);
		issue_command(CMD_READ, 8'hFF, 8'hFF, 11'(CELLS - 1));
		issue_command(CMD_READ, 8'h00, 8'h00, 11'(CELLS));
		issue_command(CMD_READ, 8'h00, 8'h00, 11'h7FF);
		issue_command(CMD_PRINT, 8'h41, 8'h00, 11'd0);
		issue_command(CMD_PRINT, 8'h00, 8'hFF, 11'd0);
		issue_command(CMD_PRINT, 8'hFF, 8'h00, 11'h7FF);
		issue_command(CMD_PUT, LINE_FEED, 8'hFF, 11'd0);
		issue_command(CMD_PUT, 8'h00, 8'h00, 11'd0);
		issue_command(CMD_READ, 8'h00, 8'h00, 11'd0);
		issue_command(CMD_READ, 8'h00, 8'h00, 11'd3);
		issue_command(CMD_READ, 8'h00, 8'h00, 11'd4);
		issue_command(CMD_PRINT, LINE_FEED, 8'h00, 11'd0);
		issue_command(CMD_READ, 8'h00, 8'h00, 11'd80);
		issue_command(CMD_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
		issue_command(CMD_READ, 8'h00, 8'h00, 11'd0);
		drain_results();
		write_attribute(8'hFF);
		issue_command(CMD_PUT, 8'h5A, 8'h12, 11'd0);
		issue_command(CMD_READ, 8'h00, 8'h00, 11'd0);
		issue_command(CMD_PRINT, 8'h42, 8'h00, 11'd0);
		issue_command(CMD_READ, 8'h00, 8'h00, 11'd81);
		issue_command(CMD_CLEAR, 8'h00, 8'h00, 11'd0);
		issue_command(CMD_READ, 8'h00, 8'h00, 11'(CELLS - 1));

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			write_attribute(attr_plan[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					quiet = ($urandom_range(0, 99) < 30);
				end
				random_command((p % 2 == 0) ? 25 : 2);
			end
		end

		drain_results();
		repeat (2 * CELLS + 16) @(posedge clk);
		$display("Summary: %0d commands (%0d print, %0d put, %0d clear, %0d read), %0d attribute writes.",
			sent_count, cmd_count[CMD_PRINT], cmd_count[CMD_PUT], cmd_count[CMD_CLEAR],
			cmd_count[CMD_READ], attr_writes);
		$display("Summary: %0d results checked, %0d of them scrolled the screen.",
			checked_count, scroll_count);
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
